FILE: rtl/box_filter_3x3_edge_mean_assert.svh
// box_filter_3x3_edge_mean_assert.svh: concurrent assertion macros for the filter top level.
// No dependencies; included by box_filter_3x3_edge_mean.sv.
`ifndef BOX_FILTER_3X3_EDGE_MEAN_ASSERT_SVH
`define BOX_FILTER_3X3_EDGE_MEAN_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define BF3EM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is high
`define BF3EM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bf3em_pkg.sv
// bf3em_pkg: shared types, widths and divider constants for the 3x3 edge-mean box filter.
// No dependencies; used by bf3em_cell, bf3em_mean and box_filter_3x3_edge_mean.
`default_nettype none

package bf3em_pkg;

  localparam int MAX_SIZE_DEF = 16;
  localparam int SIZE_MIN     = 2;
  localparam int CFG_W        = 5;
  localparam int PIX_W        = 16;
  localparam int CSUM_W       = 18;  // three samples
  localparam int WSUM_W       = 20;  // nine samples
  localparam int RECIP_W      = 22;
  localparam int RECIP_SHIFT  = 23;
  localparam int PROD_W       = WSUM_W + RECIP_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

  // floor(s * M / 2^23) == floor(s / d) for every s below 2^20
  localparam logic [RECIP_W-1:0] RECIP_4 = 22'd2097152;
  localparam logic [RECIP_W-1:0] RECIP_6 = 22'd1398102;
  localparam logic [RECIP_W-1:0] RECIP_9 = 22'd932068;

  typedef struct packed {
    logic [PIX_W-1:0] up;   // two rows above the incoming one
    logic [PIX_W-1:0] mid;  // row above the incoming one
  } cell_t;

  typedef struct packed {
    logic valid;
    logic has_left;
    logic has_right;
    logic rows3;
    logic last;
    logic end_img;
  } emit_t;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_FLUSH,
    ST_FLAST
  } seq_state_t;

  function automatic logic [RECIP_W-1:0] recip(input div_t d);
    unique case (d)
      DIV_4:   return RECIP_4;
      DIV_6:   return RECIP_6;
      DIV_9:   return RECIP_9;
      default: return RECIP_4;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bf3em_cell.sv
// bf3em_cell: one column of the rotating line chain, holding two stacked samples.
// Depends on bf3em_pkg.
`default_nettype none

module bf3em_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                shift,
  input  wire logic [IDX_W-1:0]    size_last,
  input  wire bf3em_pkg::cell_t    from_next,
  input  wire bf3em_pkg::cell_t    from_tail,
  output bf3em_pkg::cell_t         q
);

  logic is_tail;

  // the cell at column N-1 closes the ring
  assign is_tail = (size_last == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= is_tail ? from_tail : from_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bf3em_mean.sv
// bf3em_mean: three-column sliding window, window sum and reciprocal divide with output register.
// Depends on bf3em_pkg.
`default_nettype none

module bf3em_mean (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            adv,
  input  wire logic                            push,
  input  wire logic [bf3em_pkg::CSUM_W-1:0]    col_sum,
  input  wire bf3em_pkg::emit_t                emit,
  output logic                                 res_valid,
  output logic [bf3em_pkg::PIX_W-1:0]          smoothed,
  output logic                                 last_of_run,
  output logic                                 end_of_image
);

  logic [bf3em_pkg::CSUM_W-1:0]  w0;
  logic [bf3em_pkg::CSUM_W-1:0]  w1;
  logic [bf3em_pkg::CSUM_W-1:0]  w2;
  bf3em_pkg::emit_t              d1;
  logic [bf3em_pkg::WSUM_W-1:0]  win_sum;
  bf3em_pkg::div_t               div_sel;
  logic                          v2;
  logic [bf3em_pkg::WSUM_W-1:0]  sum2;
  bf3em_pkg::div_t               div2;
  logic                          last2;
  logic                          end2;
  logic [bf3em_pkg::PROD_W-1:0]  product;

  // w0 newest column, w1 the centre column, w2 its left neighbor
  always_comb begin
    win_sum = bf3em_pkg::WSUM_W'(w1)
            + (d1.has_left  ? bf3em_pkg::WSUM_W'(w2) : '0)
            + (d1.has_right ? bf3em_pkg::WSUM_W'(w0) : '0);
    if (d1.rows3 && d1.has_left && d1.has_right) begin
      div_sel = bf3em_pkg::DIV_9;
    end else if (d1.rows3 || (d1.has_left && d1.has_right)) begin
      div_sel = bf3em_pkg::DIV_6;
    end else begin
      div_sel = bf3em_pkg::DIV_4;
    end
  end

  assign product = bf3em_pkg::PROD_W'(sum2) * bf3em_pkg::PROD_W'(bf3em_pkg::recip(div2));

  always_ff @(posedge clk) begin
    if (rst) begin
      d1        <= '0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      d1        <= emit;
      v2        <= d1.valid;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (push) begin
        w2 <= w1;
        w1 <= w0;
        w0 <= col_sum;
      end
      sum2         <= win_sum;
      div2         <= div_sel;
      last2        <= d1.last;
      end2         <= d1.end_img;
      smoothed     <= product[bf3em_pkg::RECIP_SHIFT +: bf3em_pkg::PIX_W];
      last_of_run  <= last2;
      end_of_image <= end2;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/box_filter_3x3_edge_mean.sv
// box_filter_3x3_edge_mean: streaming 3x3 edge-aware box filter; uses bf3em_pkg, bf3em_cell,
// bf3em_mean and box_filter_3x3_edge_mean_assert.svh.
// Pipeline: a result goes from d1 and the window to sum2/div2, then to the output register.
// Throughput: 1 request per cycle unless the output stalls; a row-ending request (row 1 on)
// adds a close step; the image's last also a flush pass as the chain rotates the bottom row out once.
// Reset: sequencer, counters and valid bits clear, size goes to 16; line cells keep contents.
`default_nettype none

`include "box_filter_3x3_edge_mean_assert.svh"

module box_filter_3x3_edge_mean #(
  parameter int MAX_SIZE = bf3em_pkg::MAX_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bf3em_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bf3em_pkg::PIX_W-1:0]     pixel,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bf3em_pkg::PIX_W-1:0]          smoothed,
  output logic                                 last_of_run,
  output logic                                 end_of_image
);

  localparam int IDX_W = $clog2(MAX_SIZE);

  function automatic logic [IDX_W-1:0] last_index(input logic [bf3em_pkg::CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < bf3em_pkg::SIZE_MIN) n = bf3em_pkg::SIZE_MIN;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return IDX_W'(n - 1);
  endfunction

  bf3em_pkg::seq_state_t         state;
  bf3em_pkg::seq_state_t         state_next;
  logic [IDX_W-1:0]              size_last;
  logic [IDX_W-1:0]              row;
  logic [IDX_W-1:0]              row_next;
  logic [IDX_W-1:0]              col;
  logic [IDX_W-1:0]              col_next;
  logic [IDX_W-1:0]              fcol;
  logic [IDX_W-1:0]              fcol_next;
  logic                          close_rows3;
  logic                          close_rows3_next;
  logic                          final_run;
  logic                          final_run_next;

  logic                          adv;
  logic                          step;
  logic                          chain_shift;
  logic                          rot_plain;
  logic                          last_col;
  logic [bf3em_pkg::CSUM_W-1:0]  col_sum;
  bf3em_pkg::emit_t              emit;
  bf3em_pkg::cell_t              chain_q [MAX_SIZE];
  bf3em_pkg::cell_t              head;
  bf3em_pkg::cell_t              tail_data;

  assign adv  = !out_valid || out_ready;
  assign head = chain_q[0];

  // Head cell always holds the column of the next step. A request pushes (mid, pixel)
  // to the tail, aging rows by one; the flush pass rotates the ring unchanged.
  always_comb begin
    if (rot_plain) begin
      tail_data = head;
    end else begin
      tail_data.up  = head.mid;
      tail_data.mid = pixel;
    end
  end

  genvar gi;
  for (gi = 0; gi < MAX_SIZE; gi++) begin : g_cell
    bf3em_pkg::cell_t from_next;
    if (gi == MAX_SIZE - 1) begin : g_ring
      assign from_next = tail_data;
    end else begin : g_link
      assign from_next = chain_q[gi + 1];
    end
    bf3em_cell #(
      .IDX_W (IDX_W),
      .INDEX (gi)
    ) u_cell (
      .clk       (clk),
      .shift     (chain_shift),
      .size_last (size_last),
      .from_next (from_next),
      .from_tail (tail_data),
      .q         (chain_q[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bf3em_pkg::ST_IDLE;
      size_last   <= last_index(bf3em_pkg::SIZE_RESET);
      row         <= '0;
      col         <= '0;
      fcol        <= '0;
      close_rows3 <= 1'b0;
      final_run   <= 1'b0;
    end else begin
      state       <= state_next;
      fcol        <= fcol_next;
      close_rows3 <= close_rows3_next;
      final_run   <= final_run_next;
      if (cfg_write) begin
        size_last <= last_index(cfg_data);
        row       <= '0;
        col       <= '0;
      end else begin
        row <= row_next;
        col <= col_next;
      end
    end
  end

  always_comb begin
    state_next       = state;
    row_next         = row;
    col_next         = col;
    fcol_next        = fcol;
    close_rows3_next = close_rows3;
    final_run_next   = final_run;
    in_ready         = 1'b0;
    step             = 1'b0;
    chain_shift      = 1'b0;
    rot_plain        = 1'b0;
    col_sum          = '0;
    emit             = '0;
    last_col         = (col == size_last);
    unique case (state)
      bf3em_pkg::ST_IDLE: begin
        in_ready = adv;
        if (in_valid && adv) begin
          step           = 1'b1;
          chain_shift    = 1'b1;
          col_sum        = bf3em_pkg::CSUM_W'(head.mid) + bf3em_pkg::CSUM_W'(pixel)
                         + ((row > IDX_W'(1)) ? bf3em_pkg::CSUM_W'(head.up) : '0);
          // result for column col-1 of the row above
          emit.valid     = (row != '0) && (col != '0);
          emit.has_left  = (col > IDX_W'(1));
          emit.has_right = 1'b1;
          emit.rows3     = (row > IDX_W'(1));
          emit.last      = !last_col;
          if (last_col) begin
            col_next = '0;
            row_next = (row == size_last) ? '0 : row + IDX_W'(1);
            if (row != '0) begin
              state_next       = bf3em_pkg::ST_CLOSE;
              close_rows3_next = (row > IDX_W'(1));
              final_run_next   = (row == size_last);
            end
          end else begin
            col_next = col + IDX_W'(1);
          end
        end
      end
      bf3em_pkg::ST_CLOSE: begin
        if (adv) begin
          // empty column in: right edge result
          step           = 1'b1;
          emit.valid     = 1'b1;
          emit.has_left  = 1'b1;
          emit.rows3     = close_rows3;
          emit.last      = !final_run;
          fcol_next      = '0;
          state_next     = final_run ? bf3em_pkg::ST_FLUSH : bf3em_pkg::ST_IDLE;
        end
      end
      bf3em_pkg::ST_FLUSH: begin
        if (adv) begin
          // bottom row: centre is mid, no row below
          step           = 1'b1;
          chain_shift    = 1'b1;
          rot_plain      = 1'b1;
          col_sum        = bf3em_pkg::CSUM_W'(head.up) + bf3em_pkg::CSUM_W'(head.mid);
          emit.valid     = (fcol != '0);
          emit.has_left  = (fcol > IDX_W'(1));
          emit.has_right = 1'b1;
          if (fcol == size_last) begin
            state_next = bf3em_pkg::ST_FLAST;
          end else begin
            fcol_next = fcol + IDX_W'(1);
          end
        end
      end
      bf3em_pkg::ST_FLAST: begin
        if (adv) begin
          step           = 1'b1;
          emit.valid     = 1'b1;
          emit.has_left  = 1'b1;
          emit.last      = 1'b1;
          emit.end_img   = 1'b1;
          state_next     = bf3em_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bf3em_pkg::ST_IDLE;
      end
    endcase
  end

  bf3em_mean u_mean (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .push         (step),
    .col_sum      (col_sum),
    .emit         (emit),
    .res_valid    (out_valid),
    .smoothed     (smoothed),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

  `BF3EM_ASSERT_NEXT(a_final_close, clk, rst, in_valid && in_ready && (row == size_last) && (col == size_last), state == bf3em_pkg::ST_CLOSE, "last pixel of image did not start the row close")
  `BF3EM_ASSERT_NOW(a_busy_stall, clk, rst, state != bf3em_pkg::ST_IDLE, !in_ready, "request taken during close or flush")
  `BF3EM_ASSERT_NOW(a_end_is_last, clk, rst, out_valid && end_of_image, last_of_run, "end of image not marked last of run")

endmodule

`default_nettype wire

FILE: tb/tb_box_filter_3x3_edge_mean.sv
// tb_box_filter_3x3_edge_mean.sv: self-checking bench for the 3x3 edge-mean box filter.
// Needs bf3em_pkg and box_filter_3x3_edge_mean; opening table of requests, then random frames
// checked against an in-bench line-buffer model, with random gaps and output stalls.
`timescale 1ns / 100ps

module tb;

  localparam int PW            = bf3em_pkg::PIX_W;
  localparam int CW            = bf3em_pkg::CFG_W;
  localparam int LINE_DEPTH    = bf3em_pkg::MAX_SIZE_DEF;
  localparam int SETTLE_CYCLES = 2 * LINE_DEPTH + 8;
  localparam int RANDOM_PIXELS = 450;

  typedef enum logic { ROW_CFG, ROW_PIX } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [PW-1:0] value;  // sample, or size in the low bits
    logic          typed;  // expected mean given below
    logic [PW-1:0] want;
  } stim_row_t;

  typedef struct packed {
    logic [PW-1:0] value;
    logic          last_flag;
    logic          end_flag;
  } mean_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [PW-1:0] pixel = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [PW-1:0] smoothed;
  logic          last_of_run;
  logic          end_of_image;

  box_filter_3x3_edge_mean #(
    .MAX_SIZE(LINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed(smoothed),
    .last_of_run(last_of_run),
    .end_of_image(end_of_image)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // line-buffer model of the filter
  logic [CW-1:0] size_reg = bf3em_pkg::SIZE_RESET;
  logic [PW-1:0] up_row  [LINE_DEPTH];
  logic [PW-1:0] mid_row [LINE_DEPTH];
  logic [PW-1:0] low_row [LINE_DEPTH];
  int unsigned   cur_row = 0;
  int unsigned   cur_col = 0;

  mean_t pending_means[$];
  mean_t got_mean;
  int    errors = 0;
  int    results_checked = 0;
  int    images_closed = 0;
  int    pixels_sent = 0;
  int    size_writes = 0;
  bit    src_quiet = 1'b0;
  bit    sink_quiet = 1'b0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      up_row[i]  = '0;
      mid_row[i] = '0;
      low_row[i] = '0;
    end
  end

  function automatic int unsigned active_n();
    int unsigned n;
    n = size_reg;
    if (n < bf3em_pkg::SIZE_MIN) n = bf3em_pkg::SIZE_MIN;
    if (n > LINE_DEPTH) n = LINE_DEPTH;
    return n;
  endfunction

  // mean around column col of the middle row of three; rows are mid/low plus optional top
  function automatic logic [PW-1:0] box_mean(input bit with_top, input int col, input int n);
    int unsigned total;
    int unsigned cnt;
    total = 0;
    cnt = 0;
    for (int x = col - 1; x <= col + 1; x++) begin
      if (x >= 0 && x < n) begin
        total += mid_row[x];
        total += low_row[x];
        cnt += 2;
        if (with_top) begin
          total += up_row[x];
          cnt++;
        end
      end
    end
    return PW'(total / cnt);
  endfunction

  task automatic predict_pixel(input logic [PW-1:0] value, input bit typed,
                               input logic [PW-1:0] want);
    int unsigned n, r, c;
    logic [PW-1:0] vals[$];
    bit frame_end;
    mean_t m;
    n = active_n();
    r = cur_row;
    c = cur_col;
    frame_end = 1'b0;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    low_row[c] = value;
    if (r >= 1) begin
      if (c >= 1) vals.push_back(box_mean(r >= 2, int'(c) - 1, n));
      if (c == n - 1) vals.push_back(box_mean(r >= 2, int'(n) - 1, n));
      // bottom row flushes on the last pixel, rows r-1 and r only
      if (r == n - 1 && c == n - 1) begin
        frame_end = 1'b1;
        for (int x = 0; x < n; x++) vals.push_back(box_mean(1'b0, x, n));
      end
    end
    for (int k = 0; k < vals.size(); k++) begin
      m.value     = typed ? want : vals[k];
      m.last_flag = (k == vals.size() - 1);
      m.end_flag  = m.last_flag && frame_end;
      pending_means.push_back(m);
    end
    c++;
    if (c >= n) begin
      c = 0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        up_row[i]  = mid_row[i];
        mid_row[i] = low_row[i];
      end
      r++;
      if (r >= n) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_pixel(input logic [PW-1:0] value, input bit typed,
                            input logic [PW-1:0] want);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = value;
    do @(posedge clk); while (!in_ready);
    predict_pixel(value, typed, want);
    pixels_sent++;
    @(negedge clk);
  endtask

  // size writes only with the filter drained and settled; any write restarts the frame
  task automatic write_size(input logic [CW-1:0] value);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    size_reg = value;
    cur_row = 0;
    cur_col = 0;
    size_writes++;
  endtask

  // output side: random stall before each result
  initial begin : sink
    int stall;
    @(negedge clk);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h last %b end %b",
                 $time, smoothed, last_of_run, end_of_image);
        errors++;
      end else begin
        got_mean = pending_means.pop_front();
        if (smoothed !== got_mean.value) begin
          $display("%0t: smoothed expected %h actual %h", $time, got_mean.value, smoothed);
          errors++;
        end
        if (last_of_run !== got_mean.last_flag) begin
          $display("%0t: last_of_run expected %b actual %b", $time, got_mean.last_flag,
                   last_of_run);
          errors++;
        end
        if (end_of_image !== got_mean.end_flag) begin
          $display("%0t: end_of_image expected %b actual %b", $time, got_mean.end_flag,
                   end_of_image);
          errors++;
        end
      end
      results_checked++;
      if (end_of_image === 1'b1) images_closed++;
    end
  end

  stim_row_t opening_rows [29] = '{
    // size 0 runs as 2x2; all-ones image means are all ones
    '{ROW_CFG, 16'd0,    1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_PIX, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_PIX, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_PIX, 16'hFFFF, 1'b1, 16'hFFFF},
    // size 17 runs as 16; partial image, stopped just into row 1
    '{ROW_CFG, 16'd17,   1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h8000, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h0001, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h5555, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hAAAA, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h1234, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFE, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h00FF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFF00, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h0F0F, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hF0F0, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_PIX, 16'hFFFF, 1'b0, 16'h0000},
    // mid-image size write restarts at pixel (0,0); all-zero image
    '{ROW_CFG, 16'd2,    1'b0, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b1, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b1, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b1, 16'h0000},
    '{ROW_PIX, 16'h0000, 1'b1, 16'h0000}
  };

  initial begin : stimulus
    int random_sent;
    int unsigned n, remaining, len, sel;
    logic [CW-1:0] sz;
    logic [PW-1:0] v;
    bit first;
    random_sent = 0;
    first = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_CFG) write_size(opening_rows[i].value[CW-1:0]);
      else send_pixel(opening_rows[i].value, opening_rows[i].typed, opening_rows[i].want);
    end

    while (random_sent < RANDOM_PIXELS) begin
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (first) begin
        write_size(5'd16);
      end else if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) sz = CW'($urandom_range(0, 1));
        else if (sel == 1) sz = CW'($urandom_range(17, 31));
        else if (sel == 2) sz = CW'($urandom_range(6, 10));
        else sz = CW'($urandom_range(2, 5));
        write_size(sz);
      end
      n = active_n();
      remaining = n * n - (cur_row * n + cur_col);
      len = remaining;
      // big images after the first one are cut short to keep the run small
      if (!first && n > 10) len = $urandom_range(1, 3 * n);
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, remaining);
      for (int k = 0; k < len; k++) begin
        sel = $urandom_range(0, 7);
        if (sel == 0) v = '0;
        else if (sel == 1) v = '1;
        else v = PW'($urandom);
        send_pixel(v, 1'b0, '0);
        random_sent++;
      end
      first = 1'b0;
    end

    in_valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d pixels across %0d size writes (sizes 2..16, clamped and restarts)",
             pixels_sent, size_writes);
    $display("checked %0d smoothed results, %0d full images flushed",
             results_checked, images_closed);
    if (errors == 0) begin
      $display("box_filter_3x3_edge_mean: match");
    end else begin
      $display("box_filter_3x3_edge_mean: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("timeout with %0d results still pending", pending_means.size());
    $display("box_filter_3x3_edge_mean: mismatch");
    $finish;
  end

endmodule
